// ===== design/dmtlb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the direct-mapped TLB lookup/fill core.
// No dependencies; imported by every module of the block except the generic RAM.

package dmtlb_pkg;

    localparam int TLB_ENTRIES = 256;
    localparam int IDX_BITS    = $clog2(TLB_ENTRIES);
    localparam int IDX_W       = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int ADDR_W      = 32;
    localparam int TAG_W       = ADDR_W - IDX_BITS;
    localparam int CNT_W       = 32;
    localparam int OFF_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [OFF_W-1:0] OFF_MAX   = OFF_W'(24);
    localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'(12);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_OFFSET_BITS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SHIFT_PAGES = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // latch the address, start the entry read
        logic finish;   // resolve hit/miss, fill, load result register
    } dp_cmd_t;

endpackage

// ===== design/dmtlb_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the translation request and result.
// Depends on dmtlb_pkg for field widths.

interface dmtlb_in_if import dmtlb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] virt_addr;

    modport source (output valid, output virt_addr, input ready);
    modport sink   (input valid, input virt_addr, output ready);
endinterface

interface dmtlb_out_if import dmtlb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] phys_addr;
    logic              hit;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;

    modport source (output valid, output phys_addr, output hit, output hit_count,
                    output miss_count, input ready);
    modport sink   (input valid, input phys_addr, input hit, input hit_count,
                    input miss_count, output ready);
endinterface

// ===== design/dmtlb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module dmtlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dmtlb_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the TLB core: sequences accept, lookup and result transfer.
// Depends on dmtlb_pkg for the state enum and command struct.

module dmtlb_ctrl import dmtlb_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Result register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/dmtlb_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the TLB core: address split, entry store, fill, counters.
// Depends on dmtlb_pkg and the generic RAM dmtlb_ram.

module dmtlb_dp import dmtlb_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    input  logic [ADDR_W-1:0]     virt_addr,
    output logic [ADDR_W-1:0]     phys_addr,
    output logic                  hit,
    output logic [CNT_W-1:0]      hit_count,
    output logic [CNT_W-1:0]      miss_count
);

    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << IDX_BITS) - 64'd1);
    localparam logic [5:0]       IDX_SPLIT = 6'(IDX_BITS);
    localparam int               ENTRY_W = TAG_W + ADDR_W;

    // Configuration
    logic [OFF_W-1:0]  page_offset_bits_reg;
    logic [ADDR_W-1:0] frame_shift_pages_reg;

    // Address split (accept cycle)
    logic [OFF_W-1:0]  off;
    logic [ADDR_W-1:0] off_mask;
    logic [ADDR_W-1:0] shifted;
    logic [IDX_W-1:0]  idx;
    logic [5:0]        split;
    logic [ADDR_W-1:0] tag_full;
    logic [ADDR_W-1:0] frame_calc;

    // Per-item registers
    logic [IDX_W-1:0]  idx_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [ADDR_W-1:0] offset_reg;
    logic [ADDR_W-1:0] frame_calc_reg;
    logic              in_store_reg;

    // Entry store
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [ENTRY_W-1:0]     rd_entry;
    logic [TAG_W-1:0]       rd_tag;
    logic [ADDR_W-1:0]      rd_frame;
    logic                   lookup_hit;
    logic                   fill;
    logic [ADDR_W-1:0]      frame;

    // Results and counters
    logic [ADDR_W-1:0] phys_addr_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  hits_reg;
    logic [CNT_W-1:0]  misses_reg;

    assign off        = (page_offset_bits_reg > OFF_MAX) ? OFF_MAX : page_offset_bits_reg;
    assign off_mask   = (ADDR_W'(1) << off) - ADDR_W'(1);
    assign shifted    = virt_addr >> off;
    assign idx        = shifted[IDX_W-1:0] & IDX_MASK;
    assign split      = 6'(off) + IDX_SPLIT;
    assign tag_full   = virt_addr >> split;   // shift of 32 or more yields zero
    assign frame_calc = (virt_addr & ~off_mask) + (frame_shift_pages_reg << off);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_offset_bits_reg  <= OFF_RESET;
            frame_shift_pages_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PAGE_OFFSET_BITS:  page_offset_bits_reg  <= cfg_data[OFF_W-1:0];
                CFG_FRAME_SHIFT_PAGES: frame_shift_pages_reg <= cfg_data[ADDR_W-1:0];
                default:               page_offset_bits_reg  <= page_offset_bits_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg        <= idx;
            tag_reg        <= tag_full[TAG_W-1:0];
            offset_reg     <= virt_addr & off_mask;
            frame_calc_reg <= frame_calc;
            in_store_reg   <= (32'(idx) < 32'(TLB_ENTRIES));
        end
    end

    dmtlb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TLB_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (fill),
        .wr_addr (idx_reg),
        .wr_data ({tag_reg, frame_calc_reg}),
        .rd_en   (cmd.accept),
        .rd_addr (idx),
        .rd_data (rd_entry)
    );

    assign rd_tag     = rd_entry[ENTRY_W-1:ADDR_W];
    assign rd_frame   = rd_entry[ADDR_W-1:0];
    assign lookup_hit = in_store_reg && valid_reg[idx_reg] && (rd_tag == tag_reg);
    assign fill       = cmd.finish && !lookup_hit && in_store_reg;
    assign frame      = lookup_hit ? rd_frame : frame_calc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else if (cmd.finish)
        begin
            if (fill)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            // Saturate both counters at all ones
            if (lookup_hit)
            begin
                if (hits_reg != '1)
                begin
                    hits_reg <= hits_reg + CNT_W'(1);
                end
            end
            else if (misses_reg != '1)
            begin
                misses_reg <= misses_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            phys_addr_reg <= frame + offset_reg;
            hit_reg       <= lookup_hit;
        end
    end

    assign phys_addr  = phys_addr_reg;
    assign hit        = hit_reg;
    assign hit_count  = hits_reg;
    assign miss_count = misses_reg;

endmodule

// ===== design/direct_mapped_tlb_lookup_fill_core.sv =====
`timescale 1ns / 1ps
// Top level of the direct-mapped TLB lookup/fill core.
// Depends on dmtlb_pkg, dmtlb_if, dmtlb_ctrl and dmtlb_dp.
//
// Usage:
//   in_ch carries one virtual address per transfer; out_ch returns one result
//   per request: physical address, hit flag and saturating hit/miss counts
//   that include this request. The config port takes page_offset_bits
//   (index 0) and frame_shift_pages (index 1), one write per cycle with
//   cfg_wr_en high; write only while no request is in flight.
// Timing:
//   The block looks up one request at a time: the entry store read is
//   registered at acceptance, the tag compare runs in the lookup state, and
//   the result register loads once out_ch can take it; in_ch.ready returns
//   in the same cycle that the result is loaded. A new request is accepted
//   only after the previous one has left the lookup state.
// Stall:
//   The result sits in an output register; a new request can be accepted while
//   it waits, but that request holds in lookup until the old result transfers.
// Reset:
//   rst_n clears all valid bits at once (no clearing sweep), zeroes the
//   counters and loads page_offset_bits = 12, frame_shift_pages = 0.

module direct_mapped_tlb_lookup_fill_core import dmtlb_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dmtlb_in_if.sink              in_ch,
    dmtlb_out_if.source           out_ch
);

    dp_cmd_t cmd;

    // Sequencing: idle -> lookup -> idle, result register handshake
    dmtlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // Address split, entry store, fill on miss and counters
    dmtlb_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .virt_addr  (in_ch.virt_addr),
        .phys_addr  (out_ch.phys_addr),
        .hit        (out_ch.hit),
        .hit_count  (out_ch.hit_count),
        .miss_count (out_ch.miss_count)
    );

`ifndef NO_ASSERTIONS
    // One request at a time: after a transfer in, the port closes
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("request accepted while another is in flight");

    // A result appears only after a lookup cycle
    a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(!in_ch.ready))
        else $error("result shown without a preceding lookup");

    // The counters include the request they report
    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.hit |-> out_ch.hit_count != '0)
        else $error("hit reported with zero hit count");

    a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.hit |-> out_ch.miss_count != '0)
        else $error("miss reported with zero miss count");
`endif

endmodule
